// ===== rtl/asni_pkg.sv =====
// Shared types, constants and the sine table builder for the angular spring node integrator.
`timescale 1ns / 1ps
package asni_pkg;

  localparam int NODE_COUNT_DEF = 64;
  localparam int SINE_DEPTH_DEF = 256;

  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
  localparam logic [63:0] TURN_RECIP_Q32 = 64'd683565276;

  localparam logic signed [15:0] GX_RESET  = 16'sd0;
  localparam logic signed [15:0] GY_RESET  = -16'sd16384;
  localparam logic [15:0]        GS_RESET  = 16'd0;
  localparam logic [15:0]        CAP_RESET = 16'd546;

  localparam logic [1:0] CFG_GRAVITY_X        = 2'd0;
  localparam logic [1:0] CFG_GRAVITY_Y        = 2'd1;
  localparam logic [1:0] CFG_GRAVITY_STRENGTH = 2'd2;
  localparam logic [1:0] CFG_SUBSTEP_CAP      = 2'd3;

  typedef enum logic [1:0] {
    MODE_UPDATE    = 2'd0,
    MODE_TORQUE    = 2'd1,
    MODE_CLEAR     = 2'd2,
    MODE_CLEAR_ROT = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [5:0]         node_index;
    logic [15:0]        time_step;
    logic signed [15:0] local_rotation;
    logic signed [15:0] world_angle;
    logic [15:0]        stiffness;
    logic [15:0]        damping;
    logic [18:0]        max_velocity;
    logic signed [19:0] torque;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         result_node;
    logic signed [15:0] new_rotation;
    logic signed [19:0] new_velocity;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic [15:0]        gs;
    logic [15:0]        cap;
  } cfg_t;

  // Classified command handed from the front queue to the back end.
  typedef struct packed {
    mode_t              mode;
    logic [5:0]         node;
    logic               zero_step;
    logic [15:0]        time_step;
    logic signed [15:0] rot;
    logic signed [15:0] angle;
    logic [15:0]        stiff;
    logic [15:0]        damp;
    logic [18:0]        vmax;
    logic signed [19:0] torque;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ,
    ST_G0, ST_G1, ST_G2, ST_MOD_S, ST_MOD_C,
    ST_D0, ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_D6,
    ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6,
    ST_WB, ST_OUT
  } bk_state_t;

  // Sine entry for table phase p (one turn = 2^32), Q1.14, from a Taylor series.
  function automatic logic signed [15:0] sine_entry(input logic [63:0] p);
    logic [1:0]         q;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    q = p[31:30];
    r = {34'd0, p[29:0]};
    if (q[0]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = ($unsigned(sum) + 64'd32768) >> 16;
    if (v > 64'd16384) begin
      v = 64'd16384;
    end
    return q[1] ? -$signed(16'(v)) : $signed(16'(v));
  endfunction

endpackage

// ===== rtl/asni_front.sv =====
// Input side: accepts items, drops out-of-range nodes, classifies and queues commands.
`timescale 1ns / 1ps
module asni_front #(
  parameter int NODE_COUNT = asni_pkg::NODE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  asni_pkg::in_item_t in_item,
  output logic               cmd_valid,
  output asni_pkg::cmd_t     cmd_head,
  input  logic               cmd_pop
);
  import asni_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       in_range;
  logic       wr_en;
  cmd_t       cmd_new;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd_head  = q[rd_ptr];
  assign in_range  = (32'(in_item.node_index) < NODE_COUNT);
  assign wr_en     = push && !full && in_range;

  always_comb begin
    cmd_new.mode      = in_item.mode;
    cmd_new.node      = in_item.node_index;
    cmd_new.zero_step = (in_item.time_step == 16'd0);
    cmd_new.time_step = in_item.time_step;
    cmd_new.rot       = in_item.local_rotation;
    cmd_new.angle     = in_item.world_angle;
    cmd_new.stiff     = in_item.stiffness;
    cmd_new.damp      = in_item.damping;
    cmd_new.vmax      = in_item.max_velocity;
    cmd_new.torque    = in_item.torque;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= cmd_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, cmd_pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("front queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> count != 2'd0)
    else $error("front queue popped while empty");
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    wr_en && !cmd_pop |=> count == $past(count) + 2'd1)
    else $error("front queue count did not follow a write");

endmodule

// ===== rtl/asni_back.sv =====
// Back end: node state memories, gravity term, substep sequencer and result register.
`timescale 1ns / 1ps
module asni_back #(
  parameter int NODE_COUNT       = asni_pkg::NODE_COUNT_DEF,
  parameter int SINE_TABLE_DEPTH = asni_pkg::SINE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  asni_pkg::cfg_t      cfg,
  input  logic                cmd_valid,
  input  asni_pkg::cmd_t      cmd_head,
  output logic                cmd_pop,
  output asni_pkg::out_item_t out_item,
  output logic                empty,
  input  logic                pop
);
  import asni_pkg::*;

  localparam int NIW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int TW   = $clog2(SINE_TABLE_DEPTH);
  localparam int MW   = TW + 2;
  localparam logic [MW-1:0] DEP  = MW'(SINE_TABLE_DEPTH);
  localparam logic [MW-1:0] DEP2 = MW'(2 * SINE_TABLE_DEPTH);
  localparam logic [63:0] CMUL = 64'(SINE_TABLE_DEPTH) * TURN_RECIP_Q32;
  localparam logic [20:0] CLO  = CMUL[20:0];
  localparam logic [20:0] CHI  = CMUL[41:21];
  localparam logic signed [63:0] HALF44 = 64'sd1 <<< 43;
  localparam logic signed [63:0] COFF   = (64'sd1 <<< 42) * SINE_TABLE_DEPTH;

  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] P = (64'(k) << 32) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = sine_entry(P);
  end

  // A table position biased by two turns lies below four turns; two compare and
  // subtract steps bring it into one turn.
  function automatic logic [TW-1:0] wrap_pos(input logic [MW-1:0] u);
    logic [MW-1:0] w;
    w = (u >= DEP2) ? u - DEP2 : u;
    w = (w >= DEP) ? w - DEP : w;
    return TW'(w);
  endfunction

  bk_state_t state, state_next;
  cmd_t      cmd;

  logic signed [19:0] vel_mem [NODE_COUNT];
  logic signed [19:0] tq_mem  [NODE_COUNT];
  logic [NODE_COUNT-1:0] node_valid;
  logic signed [19:0] rd_vel;
  logic signed [19:0] rd_tq;
  logic               rd_valid;
  logic [NIW-1:0]     rd_addr;
  logic [NIW-1:0]     wr_addr;
  logic               mem_we;
  logic signed [19:0] wr_vel;
  logic signed [19:0] wr_tq;
  logic signed [19:0] cur_vel;
  logic signed [19:0] cur_tq;

  logic signed [37:0] ma;
  logic signed [17:0] mb;
  logic signed [55:0] p;
  logic signed [55:0] lo;

  logic signed [15:0] rot;
  logic signed [19:0] vel;
  logic signed [19:0] ptq;
  logic signed [31:0] grav;
  logic signed [31:0] dots;
  logic signed [37:0] acc;
  logic [15:0]        remaining;
  logic [15:0]        step;
  logic               first;
  logic [MW-1:0]      us;
  logic [MW-1:0]      uc;
  logic [TW-1:0]      idx_s;
  logic [TW-1:0]      idx_c;
  out_item_t          res;
  logic               out_valid;

  logic [15:0]        cap_eff;
  logic               grav_en;
  logic signed [63:0] base;
  logic signed [15:0] spos;
  logic signed [15:0] cpos;
  logic signed [20:0] tsum;
  logic signed [55:0] vrnd;
  logic signed [32:0] vsum;
  logic signed [32:0] vlim;
  logic signed [55:0] rrnd;
  logic signed [21:0] rsum;

  assign cap_eff  = (cfg.cap == 16'd0) ? 16'd1 : cfg.cap;
  assign grav_en  = (cfg.gs != 16'd0) && ((cfg.gx != 16'sd0) || (cfg.gy != 16'sd0));
  assign cur_vel  = rd_valid ? rd_vel : 20'sd0;
  assign cur_tq   = rd_valid ? rd_tq : 20'sd0;
  assign wr_addr  = NIW'(cmd.node);
  assign rd_addr  = NIW'(cmd_head.node);
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;
  assign empty    = !out_valid;

  // Sine and cosine positions; they are wrapped into the table in the two MOD states.
  assign base = (64'(p) <<< 21) + 64'(lo);
  assign spos = 16'((base + HALF44) >>> 44);
  assign cpos = 16'((base + COFF + HALF44) >>> 44);

  assign tsum = 21'(cur_tq) + 21'(cmd.torque);
  assign vrnd = (p + (56'sd1 <<< 23)) >>> 24;
  assign vsum = 33'(vel) + 33'(vrnd);
  assign vlim = 33'($signed({1'b0, cmd.vmax}));
  assign rrnd = (p + (56'sd1 <<< 15)) >>> 16;
  assign rsum = 22'(rot) + 22'(rrnd);

  always_comb begin
    state_next = state;
    ma     = 38'sd0;
    mb     = 18'sd0;
    mem_we = 1'b0;
    wr_vel = cur_vel;
    wr_tq  = cur_tq;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_READ;
      end
      ST_READ: begin
        unique case (cmd.mode) inside
          MODE_TORQUE: begin
            mem_we = 1'b1;
            if (tsum > 21'sd524287) wr_tq = 20'sd524287;
            else if (tsum < -21'sd524288) wr_tq = -20'sd524288;
            else wr_tq = 20'(tsum);
            state_next = ST_IDLE;
          end
          MODE_CLEAR, MODE_CLEAR_ROT: begin
            mem_we = 1'b1;
            wr_vel = 20'sd0;
            wr_tq  = 20'sd0;
            state_next = (cmd.mode == MODE_CLEAR_ROT) ? ST_OUT : ST_IDLE;
          end
          default: begin
            if (cmd.zero_step) state_next = ST_OUT;
            else if (grav_en) state_next = ST_G0;
            else state_next = ST_S0;
          end
        endcase
      end
      ST_G0: begin
        ma = 38'(CLO);
        mb = 18'(cmd.angle);
        state_next = ST_G1;
      end
      ST_G1: begin
        ma = 38'(CHI);
        mb = 18'(cmd.angle);
        state_next = ST_G2;
      end
      ST_G2: state_next = ST_MOD_S;
      ST_MOD_S: state_next = ST_MOD_C;
      ST_MOD_C: state_next = ST_D0;
      ST_D0: begin
        ma = 38'(sine_rom[idx_s]);
        mb = 18'(cfg.gx);
        state_next = ST_D1;
      end
      ST_D1: begin
        ma = 38'(sine_rom[idx_c]);
        mb = 18'(cfg.gy);
        state_next = ST_D2;
      end
      ST_D2: begin
        ma = 38'(sine_rom[idx_c]);
        mb = 18'(cfg.gx);
        state_next = ST_D3;
      end
      ST_D3: begin
        ma = 38'(sine_rom[idx_s]);
        mb = 18'(cfg.gy);
        state_next = ST_D4;
      end
      ST_D4: state_next = ST_D5;
      ST_D5: begin
        ma = 38'(dots);
        mb = 18'({1'b0, cfg.gs});
        state_next = ST_D6;
      end
      ST_D6: state_next = ST_S0;
      ST_S0: begin
        ma = 38'({1'b0, cmd.stiff});
        mb = 18'(rot);
        state_next = ST_S1;
      end
      ST_S1: begin
        ma = 38'(vel);
        mb = 18'({1'b0, cmd.damp});
        state_next = ST_S2;
      end
      ST_S2: state_next = ST_S3;
      ST_S3: begin
        ma = acc;
        mb = 18'({1'b0, step});
        state_next = ST_S4;
      end
      ST_S4: state_next = ST_S5;
      ST_S5: begin
        ma = 38'(vel);
        mb = 18'({1'b0, step});
        state_next = ST_S6;
      end
      ST_S6: begin
        state_next = (remaining == 16'd0) ? ST_WB : ST_S0;
      end
      ST_WB: begin
        mem_we = 1'b1;
        wr_vel = vel;
        wr_tq  = 20'sd0;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Node state: every write updates both stores together, so one valid bit covers both.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      vel_mem[wr_addr] <= wr_vel;
      tq_mem[wr_addr]  <= wr_tq;
    end
    rd_vel <= vel_mem[rd_addr];
    rd_tq  <= tq_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (mem_we) node_valid[wr_addr] <= 1'b1;
      rd_valid <= node_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_valid) cmd <= cmd_head;
      end
      ST_READ: begin
        vel       <= cur_vel;
        ptq       <= cur_tq;
        rot       <= cmd.rot;
        grav      <= 32'sd0;
        remaining <= cmd.time_step;
        first     <= 1'b1;
        res.result_node <= cmd.node;
        if (cmd.mode == MODE_CLEAR_ROT) begin
          res.new_rotation <= 16'sd0;
          res.new_velocity <= 20'sd0;
        end else begin
          res.new_rotation <= cmd.rot;
          res.new_velocity <= cur_vel;
        end
      end
      ST_G1: lo <= p;
      ST_G2: begin
        us <= MW'(18'(spos) + 18'(2 * SINE_TABLE_DEPTH));
        uc <= MW'(18'(cpos) + 18'(2 * SINE_TABLE_DEPTH));
      end
      ST_MOD_S: idx_s <= wrap_pos(us);
      ST_MOD_C: idx_c <= wrap_pos(uc);
      ST_D1: dots <= -32'(p);
      ST_D2, ST_D3, ST_D4: dots <= dots + 32'(p);
      ST_D6: grav <= 32'((p + (56'sd1 <<< 15)) >>> 16);
      ST_S0: begin
        if (remaining > cap_eff) begin
          step      <= cap_eff;
          remaining <= remaining - cap_eff;
        end else begin
          step      <= remaining;
          remaining <= 16'd0;
        end
      end
      ST_S1: acc <= -38'(p);
      ST_S2: acc <= acc - 38'(p) + 38'(grav) + (first ? (38'(ptq) <<< 8) : 38'sd0);
      ST_S4: begin
        if (vsum > vlim) vel <= 20'(vlim);
        else if (vsum < -vlim) vel <= 20'(-vlim);
        else vel <= 20'(vsum);
      end
      ST_S6: begin
        first <= 1'b0;
        if (rsum > 22'sd32767) rot <= 16'sd32767;
        else if (rsum < -22'sd32768) rot <= -16'sd32768;
        else rot <= 16'(rsum);
      end
      ST_WB: begin
        res.new_rotation <= rot;
        res.new_velocity <= vel;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && !out_valid) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && !out_valid) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  a_substep_time: assert property (@(posedge clk) disable iff (rst)
    state == ST_S0 |-> remaining != 16'd0)
    else $error("substep started with no time left");
  a_vel_clamped: assert property (@(posedge clk) disable iff (rst)
    state == ST_S5 |-> (33'(vel) <= vlim) && (33'(vel) >= -vlim))
    else $error("velocity outside its limit after clamping");
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_READ || state == ST_WB))
    else $error("node state written outside read or write-back");
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && !out_valid |=> out_valid)
    else $error("result not loaded into output register");

endmodule

// ===== rtl/angular_spring_node_integrator.sv =====
// Top level of the angular spring node integrator: configuration registers and the two halves.
`timescale 1ns / 1ps
// Each item is queued by a two-entry front queue and carried out by a sequencer that
// shares one 38x18 multiplier. Torque and clear-motion items end in the read state with no
// result; a clear of motion and rotation and an update with a zero step go from the read
// state to the output state. An update runs N substeps, where N is time_step divided by
// substep_cap rounded up; when gravity is on, the G states first form the table position,
// the two MOD states wrap the sine and cosine positions into the table, then the D states
// form the gravity term. An item with a result waits in the output state while the output
// register still holds an unread result; the front queue keeps taking items meanwhile
// until it is full.
module angular_spring_node_integrator #(
  parameter int NODE_COUNT       = asni_pkg::NODE_COUNT_DEF,
  parameter int SINE_TABLE_DEPTH = asni_pkg::SINE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  asni_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output asni_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import asni_pkg::*;

  cfg_t cfg;
  logic cmd_valid;
  cmd_t cmd_head;
  logic cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gx  <= GX_RESET;
      cfg.gy  <= GY_RESET;
      cfg.gs  <= GS_RESET;
      cfg.cap <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRAVITY_X:        cfg.gx  <= cfg_data;
        CFG_GRAVITY_Y:        cfg.gy  <= cfg_data;
        CFG_GRAVITY_STRENGTH: cfg.gs  <= cfg_data;
        CFG_SUBSTEP_CAP:      cfg.cap <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  asni_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .cmd_valid(cmd_valid),
    .cmd_head (cmd_head),
    .cmd_pop  (cmd_pop)
  );

  asni_back #(
    .NODE_COUNT      (NODE_COUNT),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(cmd_valid),
    .cmd_head (cmd_head),
    .cmd_pop  (cmd_pop),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

endmodule
